// ===== sv/integer_to_padded_ascii_core_defines.svh =====
// Assertion macros shared by the integer to padded ASCII converter.
// Expanded inside modules that provide clk and rst_n; no other dependencies.
`ifndef INTEGER_TO_PADDED_ASCII_CORE_DEFINES_SVH
`define INTEGER_TO_PADDED_ASCII_CORE_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define ITPA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itpa assertion failed");

// Antecedent implies consequent in the following cycle.
`define ITPA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itpa assertion failed");

`endif

// ===== sv/itpa_pkg.sv =====
// Package for the integer to padded ASCII converter: widths, codes, characters
// and the microcode table of the sequencer. No dependencies.
package itpa_pkg;

    localparam int VALUE_W             = 64;
    localparam int VALUE_BITS_DEF      = 64;
    localparam int MAX_FIELD_WIDTH_DEF = 63;
    localparam int CONV_W              = 3;
    localparam int FIELD_W             = 6;
    localparam int FIELD_MAX           = (1 << FIELD_W) - 1;
    localparam int CHAR_W              = 8;
    localparam int STORE_DEPTH         = 24;
    localparam int COUNT_W             = $clog2(STORE_DEPTH);
    localparam int APB_ADDR_W          = 3;
    localparam int APB_DATA_W          = 32;
    localparam int STEP_W              = 5;

    // Conversion codes.
    localparam logic [CONV_W-1:0] CONV_SDEC   = 3'd0;
    localparam logic [CONV_W-1:0] CONV_UDEC   = 3'd1;
    localparam logic [CONV_W-1:0] CONV_OCT    = 3'd2;
    localparam logic [CONV_W-1:0] CONV_HEX_LO = 3'd3;
    localparam logic [CONV_W-1:0] CONV_HEX_UP = 3'd4;

    // Register indexes (bit 2 of the byte address).
    localparam logic REG_ATTRIBUTE = 1'b0;

    // Characters.
    localparam logic [CHAR_W-1:0] CH_DIGIT0  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DABBLE,
        OP_PUSH_DIGIT,
        OP_PUSH_CHAR,
        OP_CALC_FILL,
        OP_EMIT_FILL,
        OP_READ,
        OP_EMIT_DIGIT
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_BAD_CONV,
        C_NOT_DEC,
        C_DABBLE_MORE,
        C_MORE_DIGITS,
        C_NOT_NEG,
        C_NO_X,
        C_NO_ZPFX,
        C_LEFT,
        C_NOT_LEFT,
        C_FILL_ZERO,
        C_FILL_MORE,
        C_COUNT_MORE
    } cond_t;

    typedef enum logic [1:0] {
        PFX_MINUS,
        PFX_X,
        PFX_ZERO
    } pfx_t;

    typedef struct packed {
        logic              wait_in;
        logic              emit;
        op_t               op;
        cond_t             cond;
        pfx_t              pfx;
        logic [STEP_W-1:0] target;
    } ucode_t;

    // Program addresses.
    localparam logic [STEP_W-1:0] U_IDLE        = 5'd0;
    localparam logic [STEP_W-1:0] U_CHECK       = 5'd1;
    localparam logic [STEP_W-1:0] U_BRANCH_DEC  = 5'd2;
    localparam logic [STEP_W-1:0] U_DABBLE      = 5'd3;
    localparam logic [STEP_W-1:0] U_PUSH_DIGIT  = 5'd4;
    localparam logic [STEP_W-1:0] U_TEST_NEG    = 5'd5;
    localparam logic [STEP_W-1:0] U_PUSH_MINUS  = 5'd6;
    localparam logic [STEP_W-1:0] U_TEST_X      = 5'd7;
    localparam logic [STEP_W-1:0] U_PUSH_X      = 5'd8;
    localparam logic [STEP_W-1:0] U_TEST_ZPFX   = 5'd9;
    localparam logic [STEP_W-1:0] U_PUSH_ZPFX   = 5'd10;
    localparam logic [STEP_W-1:0] U_CALC_FILL   = 5'd11;
    localparam logic [STEP_W-1:0] U_TEST_LEAD   = 5'd12;
    localparam logic [STEP_W-1:0] U_EMIT_LEAD   = 5'd13;
    localparam logic [STEP_W-1:0] U_READ        = 5'd14;
    localparam logic [STEP_W-1:0] U_EMIT_DIGIT  = 5'd15;
    localparam logic [STEP_W-1:0] U_TEST_LEFT   = 5'd16;
    localparam logic [STEP_W-1:0] U_TEST_TRAIL  = 5'd17;
    localparam logic [STEP_W-1:0] U_EMIT_TRAIL  = 5'd18;
    localparam logic [STEP_W-1:0] U_RETURN      = 5'd19;

    function automatic ucode_t uc(input logic wait_in, input logic emit, input op_t op,
                                  input cond_t cond, input pfx_t pfx,
                                  input logic [STEP_W-1:0] target);
        ucode_t u;
        u.wait_in = wait_in;
        u.emit    = emit;
        u.op      = op;
        u.cond    = cond;
        u.pfx     = pfx;
        u.target  = target;
        return u;
    endfunction

    // The control program: one word per step, jump taken when the condition holds.
    function automatic ucode_t itpa_ucode(input logic [STEP_W-1:0] pc);
        ucode_t u;
        case (pc)
            U_IDLE:       u = uc(1'b1, 1'b0, OP_LOAD,       C_NEVER,       PFX_ZERO, U_IDLE);
            U_CHECK:      u = uc(1'b0, 1'b0, OP_NONE,       C_BAD_CONV,    PFX_ZERO, U_IDLE);
            U_BRANCH_DEC: u = uc(1'b0, 1'b0, OP_NONE,       C_NOT_DEC,     PFX_ZERO, U_PUSH_DIGIT);
            U_DABBLE:     u = uc(1'b0, 1'b0, OP_DABBLE,     C_DABBLE_MORE, PFX_ZERO, U_DABBLE);
            U_PUSH_DIGIT: u = uc(1'b0, 1'b0, OP_PUSH_DIGIT, C_MORE_DIGITS, PFX_ZERO, U_PUSH_DIGIT);
            U_TEST_NEG:   u = uc(1'b0, 1'b0, OP_NONE,       C_NOT_NEG,     PFX_ZERO, U_TEST_X);
            U_PUSH_MINUS: u = uc(1'b0, 1'b0, OP_PUSH_CHAR,  C_NEVER,       PFX_MINUS, U_IDLE);
            U_TEST_X:     u = uc(1'b0, 1'b0, OP_NONE,       C_NO_X,        PFX_ZERO, U_TEST_ZPFX);
            U_PUSH_X:     u = uc(1'b0, 1'b0, OP_PUSH_CHAR,  C_NEVER,       PFX_X,    U_IDLE);
            U_TEST_ZPFX:  u = uc(1'b0, 1'b0, OP_NONE,       C_NO_ZPFX,     PFX_ZERO, U_CALC_FILL);
            U_PUSH_ZPFX:  u = uc(1'b0, 1'b0, OP_PUSH_CHAR,  C_NEVER,       PFX_ZERO, U_IDLE);
            U_CALC_FILL:  u = uc(1'b0, 1'b0, OP_CALC_FILL,  C_LEFT,        PFX_ZERO, U_READ);
            U_TEST_LEAD:  u = uc(1'b0, 1'b0, OP_NONE,       C_FILL_ZERO,   PFX_ZERO, U_READ);
            U_EMIT_LEAD:  u = uc(1'b0, 1'b1, OP_EMIT_FILL,  C_FILL_MORE,   PFX_ZERO, U_EMIT_LEAD);
            U_READ:       u = uc(1'b0, 1'b0, OP_READ,       C_NEVER,       PFX_ZERO, U_IDLE);
            U_EMIT_DIGIT: u = uc(1'b0, 1'b1, OP_EMIT_DIGIT, C_COUNT_MORE,  PFX_ZERO, U_READ);
            U_TEST_LEFT:  u = uc(1'b0, 1'b0, OP_NONE,       C_NOT_LEFT,    PFX_ZERO, U_IDLE);
            U_TEST_TRAIL: u = uc(1'b0, 1'b0, OP_NONE,       C_FILL_ZERO,   PFX_ZERO, U_IDLE);
            U_EMIT_TRAIL: u = uc(1'b0, 1'b1, OP_EMIT_FILL,  C_FILL_MORE,   PFX_ZERO, U_EMIT_TRAIL);
            U_RETURN:     u = uc(1'b0, 1'b0, OP_NONE,       C_ALWAYS,      PFX_ZERO, U_IDLE);
            default:      u = uc(1'b0, 1'b0, OP_NONE,       C_ALWAYS,      PFX_ZERO, U_IDLE);
        endcase
        return u;
    endfunction

    // ASCII character of one digit in bases up to sixteen.
    function automatic logic [CHAR_W-1:0] itpa_digit_char(input logic [3:0] d,
                                                          input logic upper);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = CH_DIGIT0 + {4'd0, d};
        end else if (upper) begin
            c = CH_UPPER_A + {4'd0, d - 4'd10};
        end else begin
            c = CH_LOWER_A + {4'd0, d - 4'd10};
        end
        return c;
    endfunction

endpackage

// ===== sv/itpa_operand_if.sv =====
// Operand channel of the integer to padded ASCII converter: valid, ready and
// one integer with its conversion spec. Depends on itpa_pkg.
interface itpa_operand_if;
    logic                               valid;
    logic                               ready;
    logic [itpa_pkg::VALUE_W-1:0]       value;
    logic [itpa_pkg::CONV_W-1:0]        conversion;
    logic [itpa_pkg::FIELD_W-1:0]       field_width;
    logic                               left_justify;
    logic                               zero_fill;
    logic                               alternate_form;

    modport source (
        output valid, value, conversion, field_width, left_justify, zero_fill,
               alternate_form,
        input  ready
    );
    modport sink (
        input  valid, value, conversion, field_width, left_justify, zero_fill,
               alternate_form,
        output ready
    );
endinterface

// ===== sv/itpa_text_if.sv =====
// Character channel of the integer to padded ASCII converter: valid, ready,
// one character and its end-of-field mark. Depends on itpa_pkg.
interface itpa_text_if;
    logic                          valid;
    logic                          ready;
    logic [itpa_pkg::CHAR_W-1:0]   character;
    logic                          last_char;

    modport source (
        output valid, character, last_char,
        input  ready
    );
    modport sink (
        input  valid, character, last_char,
        output ready
    );
endinterface

// ===== sv/itpa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No package dependencies.
module itpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 24
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== sv/integer_to_padded_ascii_core.sv =====
// Integer to padded ASCII converter, top level: microcoded sequencer and datapath.
// Depends on itpa_pkg, itpa_operand_if, itpa_text_if, itpa_ram and the defines header.
//
//   Channel   Dir   Handshake          Carries
//   operand   in    valid/ready        value, conversion, field_width, flags
//   text      out   valid/ready        character, last_char
//   apb       cfg   psel/penable       attribute_bits at byte address 0
//
// One operand is taken at a time; ready is high only at the idle step of the program.
// Decimal runs VALUE_BITS double-dabble steps; octal and hex skip them. Each stored
// character costs a push, a registered store read and an emit, each fill character an
// emit, plus the branch steps of the program.
// Reset clears the step counter, counts, output valid and the attribute register.
// A stalled text channel holds the sequencer at its emit step; nothing is lost.
`include "integer_to_padded_ascii_core_defines.svh"

module integer_to_padded_ascii_core #(
    parameter int VALUE_BITS      = itpa_pkg::VALUE_BITS_DEF,
    parameter int MAX_FIELD_WIDTH = itpa_pkg::MAX_FIELD_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    itpa_operand_if.sink                    operand,
    itpa_text_if.source                     text,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [itpa_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [itpa_pkg::APB_DATA_W-1:0] pwdata,
    output logic [itpa_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import itpa_pkg::*;

    localparam int BCD_DIGITS = (VALUE_BITS * 31) / 100 + 1;
    localparam int BCD_W      = BCD_DIGITS * 4;
    localparam int DAB_W      = $clog2(VALUE_BITS + 1);
    localparam int WIDTH_CAP  = (MAX_FIELD_WIDTH < FIELD_MAX) ? MAX_FIELD_WIDTH : FIELD_MAX;
    localparam logic [FIELD_W-1:0] WIDTH_CAP_L = FIELD_W'(WIDTH_CAP);
    localparam logic [DAB_W-1:0]   DAB_LOAD    = DAB_W'(VALUE_BITS);

    ucode_t                  cw;
    logic                    go;
    logic                    jump;
    logic                    out_free;

    logic [STEP_W-1:0]       pc_reg, pc_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [FIELD_W-1:0]      fill_reg, fill_next;
    logic                    out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]       out_char_reg, out_char_next;
    logic                    out_last_reg, out_last_next;
    logic [CHAR_W-1:0]       attr_reg, attr_next;

    logic [CONV_W-1:0]       conv_reg, conv_next;
    logic [FIELD_W-1:0]      width_reg, width_next;
    logic                    left_reg, left_next;
    logic                    zero_reg, zero_next;
    logic                    alt_reg, alt_next;
    logic                    neg_reg, neg_next;
    logic [VALUE_BITS-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]        bcd_reg, bcd_next;
    logic [DAB_W-1:0]        dab_reg, dab_next;

    logic                    is_dec, is_hex, is_oct, bad_conv;
    logic [VALUE_BITS-1:0]   op_val, bin_load;
    logic                    op_neg;
    logic [FIELD_W-1:0]      width_in;
    logic [BCD_W-1:0]        bcd_adj;
    logic [BCD_W-1:0]        bcd_sh;
    logic [VALUE_BITS-1:0]   bin_sh;
    logic                    more_digits;
    logic [3:0]              dig_val;
    logic [CHAR_W-1:0]       dig_char, pfx_char, pad_char;
    logic [FIELD_W-1:0]      fill_calc;

    logic                    ram_we, ram_re;
    logic [COUNT_W-1:0]      ram_raddr;
    logic [CHAR_W-1:0]       ram_wdata, ram_rdata;

    assign cw = itpa_ucode(pc_reg);

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ATTRIBUTE)
                    ? {{(APB_DATA_W - CHAR_W){1'b0}}, attr_reg} : '0;

    always_comb
    begin
        attr_next = attr_reg;
        if (psel && penable && pwrite && paddr[2] == REG_ATTRIBUTE)
        begin
            attr_next = pwdata[CHAR_W-1:0];
        end
    end

    // Handshakes.
    assign operand.ready  = cw.wait_in;
    assign text.valid     = out_valid_reg;
    assign text.character = out_char_reg;
    assign text.last_char = out_last_reg;
    assign out_free       = !out_valid_reg || text.ready;
    assign go = !((cw.wait_in && !operand.valid) || (cw.emit && !out_free));

    // Operand decode at load.
    assign op_val   = operand.value[VALUE_BITS-1:0];
    assign op_neg   = (operand.conversion == CONV_SDEC) && op_val[VALUE_BITS-1];
    assign bin_load = op_neg ? (~op_val + {{(VALUE_BITS - 1){1'b0}}, 1'b1}) : op_val;
    assign width_in = (operand.field_width > WIDTH_CAP_L) ? WIDTH_CAP_L
                                                          : operand.field_width;

    assign is_dec   = (conv_reg == CONV_SDEC) || (conv_reg == CONV_UDEC);
    assign is_hex   = (conv_reg == CONV_HEX_LO) || (conv_reg == CONV_HEX_UP);
    assign is_oct   = (conv_reg == CONV_OCT);
    assign bad_conv = !(is_dec || is_hex || is_oct);

    // One double-dabble step: add three to every BCD digit of five or more.
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                            : bcd_reg[4*i +: 4];
        end
    end

    assign bcd_sh      = bcd_reg >> 4;
    assign bin_sh      = is_hex ? (bin_reg >> 4) : (bin_reg >> 3);
    assign more_digits = is_dec ? (bcd_sh != '0) : (bin_sh != '0);
    assign dig_val     = is_dec ? bcd_reg[3:0] : (is_hex ? bin_reg[3:0] : {1'b0, bin_reg[2:0]});
    assign dig_char    = itpa_digit_char(dig_val, conv_reg == CONV_HEX_UP);
    assign pad_char    = (zero_reg && !left_reg) ? CH_DIGIT0 : CH_SPACE;
    assign fill_calc   = (width_reg > {1'b0, count_reg})
                         ? width_reg - {1'b0, count_reg} : '0;

    always_comb
    begin
        case (cw.pfx)
            PFX_MINUS: pfx_char = CH_MINUS;
            PFX_X:     pfx_char = CH_LOWER_X;
            PFX_ZERO:  pfx_char = CH_DIGIT0;
            default:   pfx_char = CH_DIGIT0;
        endcase
    end

    // Jump conditions.
    always_comb
    begin
        case (cw.cond)
            C_NEVER:       jump = 1'b0;
            C_ALWAYS:      jump = 1'b1;
            C_BAD_CONV:    jump = bad_conv;
            C_NOT_DEC:     jump = !is_dec;
            C_DABBLE_MORE: jump = (dab_reg != DAB_W'(1));
            C_MORE_DIGITS: jump = more_digits;
            C_NOT_NEG:     jump = !neg_reg;
            C_NO_X:        jump = !(alt_reg && is_hex);
            C_NO_ZPFX:     jump = !(alt_reg && !is_dec);
            C_LEFT:        jump = left_reg;
            C_NOT_LEFT:    jump = !left_reg;
            C_FILL_ZERO:   jump = (fill_reg == '0);
            C_FILL_MORE:   jump = (fill_reg != FIELD_W'(1));
            C_COUNT_MORE:  jump = (count_reg != COUNT_W'(1));
            default:       jump = 1'b0;
        endcase
    end

    // Datapath.
    always_comb
    begin
        pc_next        = pc_reg;
        count_next     = count_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg && !text.ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        conv_next      = conv_reg;
        width_next     = width_reg;
        left_next      = left_reg;
        zero_next      = zero_reg;
        alt_next       = alt_reg;
        neg_next       = neg_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        dab_next       = dab_reg;
        ram_we         = 1'b0;
        ram_wdata      = dig_char;
        ram_re         = 1'b0;
        ram_raddr      = count_reg - COUNT_W'(1);

        if (go)
        begin
            pc_next = jump ? cw.target : pc_reg + STEP_W'(1);
            case (cw.op)
                OP_NONE:
                begin
                end
                OP_LOAD:
                begin
                    conv_next  = operand.conversion;
                    width_next = width_in;
                    left_next  = operand.left_justify;
                    zero_next  = operand.zero_fill;
                    alt_next   = operand.alternate_form;
                    neg_next   = op_neg;
                    bin_next   = bin_load;
                    bcd_next   = '0;
                    dab_next   = DAB_LOAD;
                    count_next = '0;
                    fill_next  = '0;
                end
                OP_DABBLE:
                begin
                    bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_BITS-1]};
                    bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
                    dab_next = dab_reg - DAB_W'(1);
                end
                OP_PUSH_DIGIT:
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = dig_char;
                    count_next = count_reg + COUNT_W'(1);
                    if (is_dec)
                    begin
                        bcd_next = bcd_sh;
                    end
                    else
                    begin
                        bin_next = bin_sh;
                    end
                end
                OP_PUSH_CHAR:
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = pfx_char;
                    count_next = count_reg + COUNT_W'(1);
                end
                OP_CALC_FILL:
                begin
                    fill_next = fill_calc;
                end
                OP_EMIT_FILL:
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = pad_char | attr_reg;
                    out_last_next  = left_reg && (fill_reg == FIELD_W'(1));
                    fill_next      = fill_reg - FIELD_W'(1);
                end
                OP_READ:
                begin
                    ram_re = 1'b1;
                end
                OP_EMIT_DIGIT:
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = ram_rdata | attr_reg;
                    out_last_next  = (count_reg == COUNT_W'(1))
                                     && (!left_reg || fill_reg == '0);
                    count_next     = count_reg - COUNT_W'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= U_IDLE;
            count_reg     <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            attr_reg      <= '0;
        end
        else
        begin
            pc_reg        <= pc_next;
            count_reg     <= count_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            attr_reg      <= attr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        conv_reg     <= conv_next;
        width_reg    <= width_next;
        left_reg     <= left_next;
        zero_reg     <= zero_next;
        alt_reg      <= alt_next;
        neg_reg      <= neg_next;
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        dab_reg      <= dab_next;
    end

    itpa_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (STORE_DEPTH)
    ) u_digit_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The longest field (sign or prefix plus digits) must fit the store.
    `ITPA_ASSERT_IMP(a_count_in_store, 1'b1, count_reg < COUNT_W'(STORE_DEPTH))
    // Digits are only emitted from a non-empty store.
    `ITPA_ASSERT_IMP(a_digit_from_store, pc_reg == U_EMIT_DIGIT || pc_reg == U_READ, count_reg != '0)
    // Fill characters are only emitted while some are owed.
    `ITPA_ASSERT_IMP(a_fill_owed, pc_reg == U_EMIT_LEAD || pc_reg == U_EMIT_TRAIL, fill_reg != '0)
    // The step counter never leaves the program.
    `ITPA_ASSERT_IMP(a_pc_in_program, 1'b1, pc_reg <= U_RETURN)
    // An emitted final character returns the sequencer towards idle.
    `ITPA_ASSERT_NXT(a_last_ends_field, go && cw.emit && out_last_next, pc_reg == U_TEST_LEFT || pc_reg == U_RETURN)

endmodule

// ===== bench/integer_to_padded_ascii_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for integer_to_padded_ascii_core: a directed table, then random
// operands under several attribute settings, each field checked against its expected text.
// Depends on itpa_pkg, itpa_operand_if, itpa_text_if and the converter RTL.
module integer_to_padded_ascii_core_tb;
    import itpa_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE_CYCLES = 200;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int NUM_PHASES = 5;
    localparam logic [APB_ADDR_W-1:0] ATTR_ADDR = {REG_ATTRIBUTE, 2'b00};

    // Conversion codes that the block must ignore.
    localparam logic [CONV_W-1:0] CONV_UNDEF_5 = 3'd5;
    localparam logic [CONV_W-1:0] CONV_UNDEF_6 = 3'd6;
    localparam logic [CONV_W-1:0] CONV_UNDEF_7 = 3'd7;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [CONV_W-1:0]  conversion;
        logic [FIELD_W-1:0] field_width;
        logic               left_justify;
        logic               zero_fill;
        logic               alternate_form;
    } operand_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last_char;
    } text_beat_t;

    typedef struct {
        operand_t op;
        bit       typed;
        string    text;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    itpa_operand_if operand_ch ();
    itpa_text_if    text_ch ();

    integer_to_padded_ascii_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand_ch),
        .text    (text_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    text_beat_t        pending_chars[$];
    logic [CHAR_W-1:0] attr_shadow;
    int                idle_pct;
    int                stall_left;
    int                error_count;
    int                cycle_count;
    int                operands_sent;
    int                ignored_sent;
    int                chars_checked;
    int                attr_settings;

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver stalls come in bursts; idle_pct of zero leaves ready high throughout.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            text_ch.ready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < idle_pct)
        begin
            stall_left = $urandom_range(1, 11) - 1;
            text_ch.ready <= 1'b0;
        end
        else
        begin
            text_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        text_beat_t want;
        if (rst_n && text_ch.valid === 1'b1 && text_ch.ready === 1'b1)
        begin
            if (pending_chars.size() == 0)
            begin
                error_count++;
                $error("unexpected character %h (last_char %b)", text_ch.character,
                       text_ch.last_char);
            end
            else
            begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (text_ch.character !== want.character)
                begin
                    error_count++;
                    $error("character: expected %h, actual %h", want.character,
                           text_ch.character);
                end
                if (text_ch.last_char !== want.last_char)
                begin
                    error_count++;
                    $error("last_char: expected %b, actual %b", want.last_char,
                           text_ch.last_char);
                end
            end
        end
    end

    function automatic void expect_field(input logic [CHAR_W-1:0] chars[$]);
        text_beat_t beat;
        foreach (chars[i])
        begin
            beat.character = chars[i] | attr_shadow;
            beat.last_char = (i == chars.size() - 1);
            pending_chars.push_back(beat);
        end
    endfunction

    // Builds the whole field of one operand: fill, sign or prefix, digits, trailing fill.
    function automatic void predict_field_text(input operand_t op);
        logic [VALUE_W-1:0] mag;
        logic [CHAR_W-1:0]  body[$];
        logic [CHAR_W-1:0]  field[$];
        logic [CHAR_W-1:0]  pad;
        logic               negative;
        int unsigned        radix;
        int                 fill;
        string              numerals;
        if (op.conversion > CONV_HEX_UP)
            return;
        mag = op.value;
        negative = 1'b0;
        numerals = "0123456789abcdef";
        case (op.conversion)
            CONV_SDEC:
            begin
                radix = 10;
                if (mag[VALUE_W-1])
                begin
                    negative = 1'b1;
                    mag = -mag;
                end
            end
            CONV_UDEC:   radix = 10;
            CONV_OCT:    radix = 8;
            CONV_HEX_UP:
            begin
                radix = 16;
                numerals = "0123456789ABCDEF";
            end
            default:     radix = 16;
        endcase
        // Digits are collected least significant first, then the sign or prefix.
        do
        begin
            body.push_back(numerals[int'(mag % radix)]);
            mag = mag / radix;
        end
        while (mag != 0);
        if (negative)
            body.push_back(CH_MINUS);
        if (op.alternate_form && radix == 16)
            body.push_back(CH_LOWER_X);
        if (op.alternate_form && radix != 10)
            body.push_back(CH_DIGIT0);
        fill = (int'(op.field_width) > body.size()) ? int'(op.field_width) - body.size() : 0;
        pad = (op.zero_fill && !op.left_justify) ? CH_DIGIT0 : CH_SPACE;
        if (!op.left_justify)
            repeat (fill) field.push_back(pad);
        while (body.size() > 0)
            field.push_back(body.pop_back());
        if (op.left_justify)
            repeat (fill) field.push_back(CH_SPACE);
        expect_field(field);
    endfunction

    function automatic stim_row_t stim(input logic [VALUE_W-1:0] v, input logic [CONV_W-1:0] c,
                                       input int w, input bit l, input bit z, input bit a,
                                       input bit typed, input string t);
        stim_row_t r;
        r.op.value = v;
        r.op.conversion = c;
        r.op.field_width = FIELD_W'(w);
        r.op.left_justify = l;
        r.op.zero_fill = z;
        r.op.alternate_form = a;
        r.typed = typed;
        r.text = t;
        return r;
    endfunction

    function automatic operand_t random_operand();
        operand_t    op;
        int unsigned k;
        k = $urandom_range(0, VALUE_W - 1);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: op.value = {$urandom, $urandom};
            4, 5:       op.value = VALUE_W'($urandom_range(0, 999));
            6:
            begin
                case ($urandom_range(0, 3))
                    0:       op.value = '0;
                    1:       op.value = '1;
                    2:       op.value = {1'b1, {(VALUE_W-1){1'b0}}};
                    default: op.value = {1'b0, {(VALUE_W-1){1'b1}}};
                endcase
            end
            7:          op.value = $urandom_range(0, 1) ? (64'd1 << k) : -(64'd1 << k);
            8:          op.value = VALUE_W'($urandom);
            default:    op.value = -VALUE_W'($urandom_range(1, 999));
        endcase
        if ($urandom_range(0, 15) == 0)
            op.conversion = CONV_W'($urandom_range(int'(CONV_HEX_UP) + 1, (1 << CONV_W) - 1));
        else
            op.conversion = CONV_W'($urandom_range(0, int'(CONV_HEX_UP)));
        // Wide fields are slow to drain, so most fields stay short.
        if ($urandom_range(0, 9) == 0)
            op.field_width = FIELD_W'($urandom_range(40, FIELD_MAX));
        else
            op.field_width = FIELD_W'($urandom_range(0, 24));
        op.left_justify = 1'($urandom);
        op.zero_fill = 1'($urandom);
        op.alternate_form = 1'($urandom);
        return op;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item was taken.
    task automatic send_operand(input operand_t op, input bit typed, input string text);
        logic [CHAR_W-1:0] chars[$];
        if ($urandom_range(0, 99) < idle_pct)
        begin
            operand_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        operand_ch.valid <= 1'b1;
        operand_ch.value <= op.value;
        operand_ch.conversion <= op.conversion;
        operand_ch.field_width <= op.field_width;
        operand_ch.left_justify <= op.left_justify;
        operand_ch.zero_fill <= op.zero_fill;
        operand_ch.alternate_form <= op.alternate_form;
        do
            @(posedge clk);
        while (operand_ch.ready !== 1'b1);
        operands_sent++;
        if (op.conversion > CONV_HEX_UP)
            ignored_sent++;
        if (typed)
        begin
            for (int i = 0; i < text.len(); i++)
                chars.push_back(text[i]);
            expect_field(chars);
        end
        else
        begin
            predict_field_text(op);
        end
        @(negedge clk);
    endtask

    // An ignored operand gives no result, so the block gets extra time to go idle.
    task automatic drain();
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input logic write, input logic [CHAR_W-1:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= ATTR_ADDR;
        pwdata <= APB_DATA_W'(data);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (!write && prdata[CHAR_W-1:0] !== data)
        begin
            error_count++;
            $error("attribute_bits: expected %h, actual %h", data, prdata[CHAR_W-1:0]);
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_attribute(input logic [CHAR_W-1:0] attr);
        apb_access(1'b1, attr);
        attr_shadow = attr;
        attr_settings++;
        apb_access(1'b0, attr);
    endtask

    initial
    begin : main
        stim_row_t         directed[$];
        logic [CHAR_W-1:0] phase_attr[NUM_PHASES];
        int                phase_idle[NUM_PHASES];
        operand_t          op;
        int                counted;

        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        operand_ch.valid = 1'b0;
        operand_ch.value = '0;
        operand_ch.conversion = CONV_SDEC;
        operand_ch.field_width = '0;
        operand_ch.left_justify = 1'b0;
        operand_ch.zero_fill = 1'b0;
        operand_ch.alternate_form = 1'b0;
        text_ch.ready = 1'b0;
        attr_shadow = '0;
        idle_pct = 15;
        stall_left = 0;
        error_count = 0;
        cycle_count = 0;
        operands_sent = 0;
        ignored_sent = 0;
        chars_checked = 0;
        attr_settings = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The attribute register must read back as zero straight after reset.
        apb_access(1'b0, 8'h00);
        set_attribute(8'h00);

        directed.push_back(stim(64'd0, CONV_SDEC, 0, 0, 0, 0, 1, "0"));
        directed.push_back(stim(64'd0, CONV_OCT, 0, 0, 0, 1, 1, "00"));
        directed.push_back(stim(64'd0, CONV_HEX_LO, 0, 0, 0, 1, 1, "0x0"));
        directed.push_back(stim(64'h8000_0000_0000_0000, CONV_SDEC, 0, 0, 0, 0, 1,
                                "-9223372036854775808"));
        directed.push_back(stim(64'h7FFF_FFFF_FFFF_FFFF, CONV_SDEC, 0, 0, 0, 0, 1,
                                "9223372036854775807"));
        directed.push_back(stim('1, CONV_SDEC, 0, 0, 0, 0, 1, "-1"));
        directed.push_back(stim('1, CONV_UDEC, 0, 0, 0, 0, 1, "18446744073709551615"));
        directed.push_back(stim('1, CONV_HEX_UP, 0, 0, 0, 1, 1, "0xFFFFFFFFFFFFFFFF"));
        directed.push_back(stim('1, CONV_HEX_LO, 0, 0, 0, 0, 1, "ffffffffffffffff"));
        directed.push_back(stim(64'h0123_4567_89AB_CDEF, CONV_HEX_LO, 0, 0, 0, 0, 1,
                                "123456789abcdef"));
        directed.push_back(stim(64'd8, CONV_OCT, 0, 0, 0, 0, 1, "10"));
        directed.push_back(stim(64'd12345, CONV_UDEC, 3, 0, 1, 0, 1, "12345"));
        directed.push_back(stim(64'd1, CONV_UDEC, 1, 0, 0, 0, 1, "1"));
        directed.push_back(stim('1, CONV_UNDEF_5, 63, 0, 0, 1, 1, ""));
        directed.push_back(stim(64'd42, CONV_UNDEF_6, 10, 1, 1, 1, 1, ""));
        directed.push_back(stim(64'd0, CONV_UNDEF_7, 0, 0, 0, 0, 1, ""));
        directed.push_back(stim(64'd42, CONV_UDEC, 8, 0, 0, 0, 0, ""));
        directed.push_back(stim(64'd42, CONV_UDEC, 8, 0, 1, 0, 0, ""));
        directed.push_back(stim(-64'd42, CONV_SDEC, 8, 0, 1, 0, 0, ""));
        directed.push_back(stim(64'd42, CONV_SDEC, 8, 1, 1, 0, 0, ""));
        directed.push_back(stim(64'd255, CONV_OCT, 10, 1, 0, 1, 0, ""));
        directed.push_back(stim(64'hDEAD_BEEF, CONV_HEX_UP, 12, 0, 1, 1, 0, ""));
        directed.push_back(stim(64'd7, CONV_HEX_LO, 63, 0, 0, 0, 0, ""));
        directed.push_back(stim(64'd7, CONV_HEX_LO, 63, 1, 0, 1, 0, ""));
        directed.push_back(stim('1, CONV_OCT, 63, 0, 1, 1, 0, ""));

        foreach (directed[i])
            send_operand(directed[i].op, directed[i].typed, directed[i].text);
        operand_ch.valid <= 1'b0;
        drain();

        phase_attr[0] = 8'h80;
        phase_attr[1] = 8'hFF;
        phase_attr[2] = CHAR_W'($urandom_range(1, 254));
        phase_attr[3] = CHAR_W'($urandom_range(1, 254));
        phase_attr[4] = 8'h00;
        phase_idle[0] = 20;
        phase_idle[1] = 40;
        phase_idle[2] = 5;
        phase_idle[3] = 30;
        phase_idle[4] = 0;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_attribute(phase_attr[p]);
            idle_pct = phase_idle[p];
            counted = 0;
            while (counted < ITEMS_PER_PHASE)
            begin
                op = random_operand();
                send_operand(op, 1'b0, "");
                if (op.conversion <= CONV_HEX_UP)
                    counted++;
            end
            operand_ch.valid <= 1'b0;
            drain();
        end

        if (pending_chars.size() != 0)
        begin
            error_count++;
            $error("%0d expected characters never arrived", pending_chars.size());
        end
        $display("Sent %0d operands (%0d with an unused conversion code), checked %0d characters",
                 operands_sent, ignored_sent, chars_checked);
        $display("across %0d attribute settings in %0d cycles.", attr_settings, cycle_count);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/itpa_pkg.sv
sv/itpa_operand_if.sv
sv/itpa_text_if.sv
sv/itpa_ram.sv
sv/integer_to_padded_ascii_core.sv
bench/integer_to_padded_ascii_core_tb.sv
